>>> hw/rtl/rcmix_pkg.sv
// Shared types and constants for the RC capture and motor mixer block.
package rcmix_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int CH_IN_W  = 2;
  localparam int TS_IN_W  = 16;
  localparam int DUTY_W   = 8;
  localparam int CENTER_W = 8;
  localparam int GAIN_W   = 16;
  localparam int OFFSET_W = 20;
  localparam int TOP_W    = 16;
  localparam int VAL_W    = 16;
  localparam int PINS_W   = 4;
  localparam int PROD_W   = GAIN_W + DUTY_W;
  localparam int SDEN_W   = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_OFFS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_OFFS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP    = 3'd5;

  localparam logic [CENTER_W-1:0] CENTER_RST     = 8'd74;
  localparam logic [GAIN_W-1:0]   STEER_GAIN_RST = 16'd1998;
  localparam logic [OFFSET_W-1:0] STEER_OFFS_RST = 20'd97902;
  localparam logic [GAIN_W-1:0]   THR_GAIN_RST   = 16'd3996;
  localparam logic [OFFSET_W-1:0] THR_OFFS_RST   = 20'd295704;
  localparam logic [TOP_W-1:0]    PWM_TOP_RST    = 16'd999;

  localparam logic [CH_IN_W-1:0] STEER_CH    = 2'd1;
  localparam logic [CH_IN_W-1:0] THROTTLE_CH = 2'd2;

  localparam logic [DUTY_W-1:0] DUTY_MAX  = 8'hFF;
  localparam logic [VAL_W-1:0]  VAL_MAX   = 16'hFFFF;
  localparam logic [SDEN_W-1:0] SCALE_DEN = 7'd100;

  localparam logic [PINS_W-1:0] PINS_REVERSE = 4'd5;
  localparam logic [PINS_W-1:0] PINS_STOP    = 4'd15;
  localparam logic [PINS_W-1:0] PINS_FORWARD = 4'd10;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

>>> hw/rtl/rcmix_sdiv.sv
// Radix-2 restoring divider, one quotient bit per cycle, with overflow check.
module rcmix_sdiv #(
  parameter int NW = 26,
  parameter int DW = 16,
  parameter int QW = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NW-1:0]            num,
  input  logic [DW-1:0]            den,
  output rcmix_pkg::div_stat_t     stat,
  output logic [QW-1:0]            quo
);

  localparam int SW = (NW > DW + QW) ? NW : DW + QW;
  localparam int CW = $clog2(QW + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CHK  = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  logic [1:0]    phase_r, phase_nxt;
  logic [SW-1:0] rem_r, dsh_r;
  logic [QW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          done_r, ovf_r;
  logic          ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: if (start) phase_nxt = PH_CHK;
      PH_CHK:  phase_nxt = ge ? PH_IDLE : PH_RUN;
      PH_RUN:  if (cnt_r == CW'(1)) phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= 1'b0;
      if (phase_r == PH_CHK) begin
        ovf_r <= ge;
        if (ge) done_r <= 1'b1;
      end
      if (phase_r == PH_RUN && cnt_r == CW'(1)) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          rem_r <= SW'(num);
          dsh_r <= SW'(den) << QW;
          cnt_r <= CW'(QW);
        end
      end
      PH_CHK: dsh_r <= dsh_r >> 1;
      PH_RUN: begin
        if (ge) rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[QW-2:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - CW'(1);
      end
      default: ;
    endcase
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quo       = quo_r;

endmodule

>>> hw/rtl/rcmix_smul.sv
// Serial shift-add multiplier, one multiplier bit per cycle.
module rcmix_smul #(
  parameter int AW = 16,
  parameter int BW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] acc_r, mcand_r;
  logic [BW-1:0] mplier_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (start) begin
        acc_r    <= '0;
        mcand_r  <= PW'(a);
        mplier_r <= b;
        cnt_r    <= CW'(BW);
      end
    end else begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      cnt_r    <= cnt_r - CW'(1);
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> hw/rtl/rc_pwm_capture_motor_mixer.sv
// A rising edge, out of range channel or zero period goes straight to the output stage.
// A falling edge with a period runs the duty divide; steering/throttle adds a serial multiply
// and a divide by 100, skipped when the product is below the offset; throttle then mixes.
// One word in flight: in_stall stays high until the result is registered.
// Synchronous active-low reset holds in_stall, clears all channel state and the steer/throttle
// values, and loads the configuration registers with their defaults.
module rc_pwm_capture_motor_mixer #(
  parameter int NUM_CHANNELS = 4,
  parameter int TIMER_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rcmix_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcmix_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rcmix_pkg::CH_IN_W-1:0]        in_channel,
  input  logic [rcmix_pkg::TS_IN_W-1:0]        in_timestamp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rcmix_pkg::CH_IN_W-1:0]        out_channel_out,
  output logic                                 out_duty_valid,
  output logic [rcmix_pkg::DUTY_W-1:0]         out_duty_permille,
  output logic                                 out_drive_valid,
  output logic [rcmix_pkg::PINS_W-1:0]         out_dir_pins,
  output logic [rcmix_pkg::VAL_W-1:0]          out_compare_a,
  output logic [rcmix_pkg::VAL_W-1:0]          out_compare_b
);

  localparam int CH_W = $clog2(NUM_CHANNELS);
  localparam int DNW  = TIMER_BITS + 10;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DDIV = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SDIV = 3'd4;
  localparam logic [2:0] S_MIX  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [rcmix_pkg::CENTER_W-1:0] center_r;
  logic [rcmix_pkg::GAIN_W-1:0]   steer_gain_r, thr_gain_r;
  logic [rcmix_pkg::OFFSET_W-1:0] steer_offs_r, thr_offs_r;
  logic [rcmix_pkg::TOP_W-1:0]    pwm_top_r;

  // per-channel capture state
  logic                          ef_r        [NUM_CHANNELS];
  logic [TIMER_BITS-1:0]         last_rise_r [NUM_CHANNELS];
  logic [TIMER_BITS-1:0]         this_rise_r [NUM_CHANNELS];
  logic [TIMER_BITS-1:0]         period_r    [NUM_CHANNELS];
  logic [rcmix_pkg::DUTY_W-1:0]  duty_r      [NUM_CHANNELS];
  logic [rcmix_pkg::VAL_W-1:0]   steer_val_r, thr_val_r;

  logic [rcmix_pkg::CH_IN_W-1:0] ch_r;
  logic [TIMER_BITS-1:0]         ts_r;

  // staged result
  logic                          res_dv_r, res_drv_r;
  logic [rcmix_pkg::DUTY_W-1:0]  res_duty_r;
  logic [rcmix_pkg::PINS_W-1:0]  res_pins_r;
  logic [rcmix_pkg::VAL_W-1:0]   res_ca_r, res_cb_r;

  // output register
  logic                          out_valid_r;
  logic [rcmix_pkg::CH_IN_W-1:0] out_ch_r;
  logic                          out_dv_r, out_drv_r;
  logic [rcmix_pkg::DUTY_W-1:0]  out_duty_r;
  logic [rcmix_pkg::PINS_W-1:0]  out_pins_r;
  logic [rcmix_pkg::VAL_W-1:0]   out_ca_r, out_cb_r;

  logic [CH_W-1:0]               idx;
  logic                          in_range, is_steer, is_thr, out_free;
  logic [TIMER_BITS-1:0]         rise_prd, high;
  logic [DNW-1:0]                ddiv_num;
  logic                          ddiv_start, mul_start, sdiv_start;
  rcmix_pkg::div_stat_t          ddiv_stat, sdiv_stat;
  logic [rcmix_pkg::DUTY_W-1:0]  ddiv_quo, duty_new;
  logic                          mul_done;
  logic [rcmix_pkg::GAIN_W-1:0]  mul_a;
  logic [rcmix_pkg::PROD_W-1:0]  prod, sdiv_num;
  logic [rcmix_pkg::OFFSET_W-1:0] offs;
  logic                          under;
  logic [rcmix_pkg::VAL_W-1:0]   sdiv_quo, scaled;
  logic                          store_scaled;
  logic [rcmix_pkg::VAL_W-1:0]   rev;
  logic [rcmix_pkg::DUTY_W-1:0]  steer_duty;
  logic [rcmix_pkg::PINS_W-1:0]  mix_pins;
  logic [rcmix_pkg::VAL_W-1:0]   mix_ca, mix_cb;

  assign idx      = CH_W'(ch_r);
  assign in_range = (32'(ch_r) < NUM_CHANNELS);
  assign is_steer = (ch_r == rcmix_pkg::STEER_CH);
  assign is_thr   = (ch_r == rcmix_pkg::THROTTLE_CH);
  assign out_free = !out_valid_r || !out_stall;

  assign rise_prd = (last_rise_r[idx] == '0) ? '0 : ts_r - last_rise_r[idx];
  assign high     = ts_r - this_rise_r[idx];
  // high * 1000 = high * (1024 - 16 - 8)
  assign ddiv_num = (DNW'(high) << 10) - (DNW'(high) << 4) - (DNW'(high) << 3);

  assign ddiv_start = (state_r == S_EVAL) && in_range && ef_r[idx] && (period_r[idx] != '0);
  assign duty_new   = ddiv_stat.ovf ? rcmix_pkg::DUTY_MAX : ddiv_quo;

  assign mul_start = (state_r == S_DDIV) && ddiv_stat.done && (is_steer || is_thr);
  assign mul_a     = is_thr ? thr_gain_r : steer_gain_r;

  assign offs       = is_thr ? thr_offs_r : steer_offs_r;
  assign under      = prod < rcmix_pkg::PROD_W'(offs);
  assign sdiv_num   = prod - rcmix_pkg::PROD_W'(offs);
  assign sdiv_start = (state_r == S_MUL) && mul_done && !under;

  // a negative numerator clamps to zero without dividing
  assign scaled = (state_r == S_SDIV) ?
                  (sdiv_stat.ovf ? rcmix_pkg::VAL_MAX : sdiv_quo) : '0;
  assign store_scaled = ((state_r == S_MUL) && mul_done && under) ||
                        ((state_r == S_SDIV) && sdiv_stat.done);

  assign rev        = pwm_top_r - thr_val_r;
  assign steer_duty = duty_r[CH_W'(rcmix_pkg::STEER_CH)];

  always_comb begin
    mix_pins = rcmix_pkg::PINS_FORWARD;
    mix_ca   = rev;
    mix_cb   = rev;
    if (res_duty_r < center_r) begin
      mix_pins = rcmix_pkg::PINS_REVERSE;
    end else if (res_duty_r == center_r) begin
      mix_pins = rcmix_pkg::PINS_STOP;
      mix_ca   = '0;
      mix_cb   = '0;
    end else if (steer_duty < center_r) begin
      mix_ca = pwm_top_r - steer_val_r;
    end else if (steer_duty > center_r) begin
      mix_cb = steer_val_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = ddiv_start ? S_DDIV : S_FIN;
      S_DDIV: if (ddiv_stat.done) state_nxt = mul_start ? S_MUL : S_FIN;
      S_MUL: begin
        if (mul_done) begin
          if (!under)      state_nxt = S_SDIV;
          else if (is_thr) state_nxt = S_MIX;
          else             state_nxt = S_FIN;
        end
      end
      S_SDIV: if (sdiv_stat.done) state_nxt = is_thr ? S_MIX : S_FIN;
      S_MIX:  state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      center_r     <= rcmix_pkg::CENTER_RST;
      steer_gain_r <= rcmix_pkg::STEER_GAIN_RST;
      steer_offs_r <= rcmix_pkg::STEER_OFFS_RST;
      thr_gain_r   <= rcmix_pkg::THR_GAIN_RST;
      thr_offs_r   <= rcmix_pkg::THR_OFFS_RST;
      pwm_top_r    <= rcmix_pkg::PWM_TOP_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ef_r[i]        <= 1'b0;
        last_rise_r[i] <= '0;
        this_rise_r[i] <= '0;
        period_r[i]    <= '0;
        duty_r[i]      <= '0;
      end
      steer_val_r <= '0;
      thr_val_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rcmix_pkg::CFG_CENTER:     center_r     <= cfg_data[rcmix_pkg::CENTER_W-1:0];
          rcmix_pkg::CFG_STEER_GAIN: steer_gain_r <= cfg_data[rcmix_pkg::GAIN_W-1:0];
          rcmix_pkg::CFG_STEER_OFFS: steer_offs_r <= cfg_data[rcmix_pkg::OFFSET_W-1:0];
          rcmix_pkg::CFG_THR_GAIN:   thr_gain_r   <= cfg_data[rcmix_pkg::GAIN_W-1:0];
          rcmix_pkg::CFG_THR_OFFS:   thr_offs_r   <= cfg_data[rcmix_pkg::OFFSET_W-1:0];
          rcmix_pkg::CFG_PWM_TOP:    pwm_top_r    <= cfg_data[rcmix_pkg::TOP_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_EVAL && in_range) begin
        if (!ef_r[idx]) begin
          period_r[idx]    <= rise_prd;
          last_rise_r[idx] <= ts_r;
          this_rise_r[idx] <= ts_r;
          ef_r[idx]        <= 1'b1;
        end else begin
          ef_r[idx] <= 1'b0;
        end
      end
      if (state_r == S_DDIV && ddiv_stat.done) duty_r[idx] <= duty_new;
      if (store_scaled) begin
        if (is_thr) thr_val_r   <= scaled;
        else        steer_val_r <= scaled;
      end
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)              out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      ch_r <= in_channel;
      ts_r <= TIMER_BITS'(in_timestamp);
    end
    case (state_r)
      S_EVAL: begin
        res_dv_r   <= 1'b0;
        res_drv_r  <= 1'b0;
        res_duty_r <= '0;
        res_pins_r <= '0;
        res_ca_r   <= '0;
        res_cb_r   <= '0;
      end
      S_DDIV: begin
        if (ddiv_stat.done) begin
          res_dv_r   <= 1'b1;
          res_duty_r <= duty_new;
        end
      end
      S_MIX: begin
        res_drv_r  <= 1'b1;
        res_pins_r <= mix_pins;
        res_ca_r   <= mix_ca;
        res_cb_r   <= mix_cb;
      end
      S_FIN: begin
        if (out_free) begin
          out_ch_r   <= ch_r;
          out_dv_r   <= res_dv_r;
          out_duty_r <= res_duty_r;
          out_drv_r  <= res_drv_r;
          out_pins_r <= res_pins_r;
          out_ca_r   <= res_ca_r;
          out_cb_r   <= res_cb_r;
        end
      end
      default: ;
    endcase
  end

  rcmix_sdiv #(
    .NW (DNW),
    .DW (TIMER_BITS),
    .QW (rcmix_pkg::DUTY_W)
  ) u_duty_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ddiv_start),
    .num   (ddiv_num),
    .den   (period_r[idx]),
    .stat  (ddiv_stat),
    .quo   (ddiv_quo)
  );

  rcmix_smul #(
    .AW (rcmix_pkg::GAIN_W),
    .BW (rcmix_pkg::DUTY_W)
  ) u_scale_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (duty_new),
    .done  (mul_done),
    .prod  (prod)
  );

  rcmix_sdiv #(
    .NW (rcmix_pkg::PROD_W),
    .DW (rcmix_pkg::SDEN_W),
    .QW (rcmix_pkg::VAL_W)
  ) u_scale_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sdiv_start),
    .num   (sdiv_num),
    .den   (rcmix_pkg::SCALE_DEN),
    .stat  (sdiv_stat),
    .quo   (sdiv_quo)
  );

  assign in_stall          = (state_r != S_IDLE) || !rst_n;
  assign out_valid         = out_valid_r;
  assign out_channel_out   = out_ch_r;
  assign out_duty_valid    = out_dv_r;
  assign out_duty_permille = out_duty_r;
  assign out_drive_valid   = out_drv_r;
  assign out_dir_pins      = out_pins_r;
  assign out_compare_a     = out_ca_r;
  assign out_compare_b     = out_cb_r;

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    (ddiv_stat.done || sdiv_stat.done) |-> (state_r == S_DDIV || state_r == S_SDIV))
    else $error("divider finished outside a wait state");

  a_drive_needs_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drive_valid) |->
      (out_duty_valid && out_channel_out == rcmix_pkg::THROTTLE_CH))
    else $error("drive update without a throttle duty");

  a_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_duty_valid) |-> (out_duty_permille == '0 && !out_drive_valid))
    else $error("stale duty on a word without a duty");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EVAL))
    else $error("accepted word not evaluated");

endmodule

>>> sim/rc_pwm_capture_motor_mixer_tb.sv
// Self-checking testbench for the RC capture and differential-drive mixer.
module rc_pwm_capture_motor_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH         = 4;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [rcmix_pkg::CH_IN_W-1:0] chan;
    logic                          duty_ok;
    logic [rcmix_pkg::DUTY_W-1:0]  duty;
    logic                          drive_ok;
    logic [rcmix_pkg::PINS_W-1:0]  pins;
    logic [rcmix_pkg::VAL_W-1:0]   cmp_a;
    logic [rcmix_pkg::VAL_W-1:0]   cmp_b;
  } mix_word_t;

  typedef struct packed {
    logic [rcmix_pkg::CENTER_W-1:0] center;
    logic [rcmix_pkg::GAIN_W-1:0]   steer_gain;
    logic [rcmix_pkg::OFFSET_W-1:0] steer_offs;
    logic [rcmix_pkg::GAIN_W-1:0]   thr_gain;
    logic [rcmix_pkg::OFFSET_W-1:0] thr_offs;
    logic [rcmix_pkg::TOP_W-1:0]    top;
  } mix_cfg_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [rcmix_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rcmix_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [rcmix_pkg::CH_IN_W-1:0]    in_channel = '0;
  logic [rcmix_pkg::TS_IN_W-1:0]    in_timestamp = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [rcmix_pkg::CH_IN_W-1:0]    out_channel_out;
  logic                             out_duty_valid;
  logic [rcmix_pkg::DUTY_W-1:0]     out_duty_permille;
  logic                             out_drive_valid;
  logic [rcmix_pkg::PINS_W-1:0]     out_dir_pins;
  logic [rcmix_pkg::VAL_W-1:0]      out_compare_a;
  logic [rcmix_pkg::VAL_W-1:0]      out_compare_b;

  rc_pwm_capture_motor_mixer uut (.*);

  // capture/mixer state mirrored on the testbench side
  mix_cfg_t                       mix_cfg;
  logic                           cap_falling [NUM_CH];
  logic [rcmix_pkg::TS_IN_W-1:0]  cap_rise    [NUM_CH];
  logic [rcmix_pkg::TS_IN_W-1:0]  cap_per     [NUM_CH];
  logic [rcmix_pkg::DUTY_W-1:0]   cap_duty    [NUM_CH];
  logic [rcmix_pkg::VAL_W-1:0]    steer_val;
  logic [rcmix_pkg::VAL_W-1:0]    thr_val;

  mix_word_t                      mix_words_due [$];
  logic [rcmix_pkg::TS_IN_W-1:0]  nominal_per [NUM_CH];
  int                             mismatch_cnt = 0;
  int                             send_idle_pct = 0;
  int                             recv_idle_pct = 0;
  int                             hold_req_cnt = 0;
  int                             hold_seen = 0;
  int                             hold_left = 0;
  int                             quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [rcmix_pkg::VAL_W-1:0] duty_to_drive(
      input logic [rcmix_pkg::GAIN_W-1:0]   gain,
      input logic [rcmix_pkg::OFFSET_W-1:0] offs,
      input logic [rcmix_pkg::DUTY_W-1:0]   d);
    longint num;
    num = longint'(gain) * longint'(d) - longint'(offs);
    if (num < 0) return '0;
    num = num / longint'(rcmix_pkg::SCALE_DEN);
    if (num > longint'(rcmix_pkg::VAL_MAX)) return rcmix_pkg::VAL_MAX;
    return num[rcmix_pkg::VAL_W-1:0];
  endfunction

  function automatic mix_word_t capture_and_mix(input logic [rcmix_pkg::CH_IN_W-1:0] ch,
                                                input logic [rcmix_pkg::TS_IN_W-1:0] ts);
    mix_word_t                     w;
    logic [rcmix_pkg::TS_IN_W-1:0] high;
    logic [rcmix_pkg::VAL_W-1:0]   rev;
    logic [rcmix_pkg::DUTY_W-1:0]  d;
    logic [rcmix_pkg::DUTY_W-1:0]  st;
    longint                        q;
    w = '0;
    w.chan = ch;
    if (!cap_falling[ch]) begin
      // a rise at timestamp zero leaves the next period unmeasured
      cap_per[ch] = (cap_rise[ch] == '0) ? '0 : rcmix_pkg::TS_IN_W'(ts - cap_rise[ch]);
      cap_rise[ch] = ts;
      cap_falling[ch] = 1'b1;
    end else begin
      high = ts - cap_rise[ch];
      if (cap_per[ch] != '0) begin
        q = (longint'(high) * 1000) / longint'(cap_per[ch]);
        d = (q > longint'(rcmix_pkg::DUTY_MAX)) ? rcmix_pkg::DUTY_MAX
                                                : q[rcmix_pkg::DUTY_W-1:0];
        cap_duty[ch] = d;
        w.duty_ok = 1'b1;
        w.duty = d;
        if (ch == rcmix_pkg::STEER_CH) begin
          steer_val = duty_to_drive(mix_cfg.steer_gain, mix_cfg.steer_offs, d);
        end else if (ch == rcmix_pkg::THROTTLE_CH) begin
          thr_val = duty_to_drive(mix_cfg.thr_gain, mix_cfg.thr_offs, d);
          rev = mix_cfg.top - thr_val;
          w.drive_ok = 1'b1;
          if (d < mix_cfg.center) begin
            w.pins = rcmix_pkg::PINS_REVERSE;
            w.cmp_a = rev;
            w.cmp_b = rev;
          end else if (d == mix_cfg.center) begin
            w.pins = rcmix_pkg::PINS_STOP;
          end else begin
            w.pins = rcmix_pkg::PINS_FORWARD;
            st = cap_duty[rcmix_pkg::STEER_CH];
            if (st < mix_cfg.center) begin
              w.cmp_a = mix_cfg.top - steer_val;
              w.cmp_b = rev;
            end else if (st == mix_cfg.center) begin
              w.cmp_a = rev;
              w.cmp_b = rev;
            end else begin
              w.cmp_a = rev;
              w.cmp_b = steer_val;
            end
          end
        end
      end
      cap_falling[ch] = 1'b0;
    end
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    mix_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (mix_words_due.size() == 0) begin
        $error("unexpected word: channel_out %0d", out_channel_out);
        mismatch_cnt++;
      end else begin
        want = mix_words_due.pop_front();
        check_field("channel_out", 32'(want.chan), 32'(out_channel_out));
        check_field("duty_valid", 32'(want.duty_ok), 32'(out_duty_valid));
        check_field("duty_permille", 32'(want.duty), 32'(out_duty_permille));
        check_field("drive_valid", 32'(want.drive_ok), 32'(out_drive_valid));
        check_field("dir_pins", 32'(want.pins), 32'(out_dir_pins));
        check_field("compare_a", 32'(want.cmp_a), 32'(out_compare_a));
        check_field("compare_b", 32'(want.cmp_b), 32'(out_compare_b));
      end
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req_cnt) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_seen <= hold_req_cnt;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_word(input logic [rcmix_pkg::CH_IN_W-1:0] ch,
                           input logic [rcmix_pkg::TS_IN_W-1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_channel <= ch;
    in_timestamp <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mix_words_due.push_back(capture_and_mix(ch, ts));
    @(negedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    while (mix_words_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_cfg(input mix_cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= rcmix_pkg::CFG_CENTER;
    cfg_data <= rcmix_pkg::CFG_DATA_W'(c.center);
    @(negedge clk);
    cfg_index <= rcmix_pkg::CFG_STEER_GAIN;
    cfg_data <= rcmix_pkg::CFG_DATA_W'(c.steer_gain);
    @(negedge clk);
    cfg_index <= rcmix_pkg::CFG_STEER_OFFS;
    cfg_data <= rcmix_pkg::CFG_DATA_W'(c.steer_offs);
    @(negedge clk);
    cfg_index <= rcmix_pkg::CFG_THR_GAIN;
    cfg_data <= rcmix_pkg::CFG_DATA_W'(c.thr_gain);
    @(negedge clk);
    cfg_index <= rcmix_pkg::CFG_THR_OFFS;
    cfg_data <= rcmix_pkg::CFG_DATA_W'(c.thr_offs);
    @(negedge clk);
    cfg_index <= rcmix_pkg::CFG_PWM_TOP;
    cfg_data <= rcmix_pkg::CFG_DATA_W'(c.top);
    @(negedge clk);
    cfg_we <= 1'b0;
    mix_cfg = c;
    @(negedge clk);
  endtask

  task automatic set_idle(input int snd, input int rcv);
    send_idle_pct = snd;
    recv_idle_pct <= rcv;
  endtask

  // Mostly well-formed pulse trains aimed around the stick centre, some noise.
  task automatic send_pwm_edge();
    logic [rcmix_pkg::CH_IN_W-1:0] ch;
    logic [rcmix_pkg::TS_IN_W-1:0] span;
    int                            pick;
    int                            target;
    int                            high;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_word(rcmix_pkg::CH_IN_W'($urandom_range(3)),
                rcmix_pkg::TS_IN_W'($urandom_range(16'hFFFF)));
      return;
    end
    pick = $urandom_range(99);
    ch = (pick < 40) ? rcmix_pkg::THROTTLE_CH : (pick < 75) ? rcmix_pkg::STEER_CH :
         (pick < 88) ? 2'd0 : 2'd3;
    pick = $urandom_range(99);
    if (!cap_falling[ch]) begin
      if (pick < 70) begin
        span = nominal_per[ch] + rcmix_pkg::TS_IN_W'($urandom_range(20)) - 16'd10;
      end else if (pick < 90) begin
        span = rcmix_pkg::TS_IN_W'($urandom_range(1000, 65535));
      end else begin
        span = rcmix_pkg::TS_IN_W'($urandom_range(1, 999));
      end
      nominal_per[ch] = span;
      send_word(ch, cap_rise[ch] + span);
    end else begin
      span = (cap_per[ch] != '0) ? cap_per[ch] : nominal_per[ch];
      if (pick < 15) begin
        high = (int'(mix_cfg.center) * int'(span) + 999) / 1000;
      end else if (pick < 80) begin
        target = int'(mix_cfg.center) + int'($urandom_range(60)) - 30;
        if (target < 0) target = 0;
        high = target * int'(span) / 1000;
      end else begin
        high = int'($urandom_range(1100)) * int'(span) / 1000;
      end
      send_word(ch, rcmix_pkg::TS_IN_W'(int'(cap_rise[ch]) + high));
    end
  endtask

  task automatic test_directed_edges();
    // zero start time, zero period, timer wrap, equal timestamps
    send_word(2'd0, 16'd0);
    send_word(2'd0, 16'd500);
    send_word(2'd0, 16'd1000);
    send_word(2'd0, 16'd1100);
    send_word(2'd0, 16'd65000);
    send_word(2'd0, 16'd300);
    send_word(2'd0, 16'd65535);
    send_word(2'd0, 16'd65535);
    send_word(2'd0, 16'd65535);
    send_word(2'd0, 16'd0);
    // one-tick period with a full-range high time saturates the duty
    send_word(2'd3, 16'd100);
    send_word(2'd3, 16'd200);
    send_word(2'd3, 16'd101);
    send_word(2'd3, 16'd100);
    // steering above centre, then throttle at stop, right turn, reverse
    send_word(rcmix_pkg::STEER_CH, 16'd1000);
    send_word(rcmix_pkg::STEER_CH, 16'd1400);
    send_word(rcmix_pkg::STEER_CH, 16'd21000);
    send_word(rcmix_pkg::STEER_CH, 16'd22700);
    send_word(rcmix_pkg::THROTTLE_CH, 16'd5000);
    send_word(rcmix_pkg::THROTTLE_CH, 16'd5100);
    send_word(rcmix_pkg::THROTTLE_CH, 16'd25000);
    send_word(rcmix_pkg::THROTTLE_CH, 16'd26480);
    send_word(rcmix_pkg::THROTTLE_CH, 16'd45000);
    send_word(rcmix_pkg::THROTTLE_CH, 16'd47000);
    send_word(rcmix_pkg::THROTTLE_CH, 16'd65000);
    send_word(rcmix_pkg::THROTTLE_CH, 16'd464);
    go_quiet();
  endtask

  task automatic test_random_capture(input int n_words);
    repeat (n_words) send_pwm_edge();
    go_quiet();
  endtask

  task automatic test_config_settings();
    mix_cfg_t c;
    c = '0;
    apply_cfg(c);
    test_random_capture(30);
    c = '{center: rcmix_pkg::DUTY_MAX, steer_gain: 16'hFFFF, steer_offs: 20'hFFFFF,
          thr_gain: 16'hFFFF, thr_offs: 20'hFFFFF, top: 16'hFFFF};
    apply_cfg(c);
    test_random_capture(30);
    c = '{center: 8'd90, steer_gain: 16'hFFFF, steer_offs: 20'd0,
          thr_gain: 16'hFFFF, thr_offs: 20'd0, top: 16'd100};
    apply_cfg(c);
    test_random_capture(30);
    repeat (2) begin
      c.center = rcmix_pkg::CENTER_W'($urandom_range(40, 130));
      c.steer_gain = rcmix_pkg::GAIN_W'($urandom_range(16'hFFFF));
      c.steer_offs = rcmix_pkg::OFFSET_W'($urandom_range(20'hFFFFF));
      c.thr_gain = rcmix_pkg::GAIN_W'($urandom_range(16'hFFFF));
      c.thr_offs = rcmix_pkg::OFFSET_W'($urandom_range(20'hFFFFF));
      c.top = rcmix_pkg::TOP_W'($urandom_range(16'hFFFF));
      apply_cfg(c);
      test_random_capture(30);
    end
    c = '{center: rcmix_pkg::CENTER_RST, steer_gain: rcmix_pkg::STEER_GAIN_RST,
          steer_offs: rcmix_pkg::STEER_OFFS_RST, thr_gain: rcmix_pkg::THR_GAIN_RST,
          thr_offs: rcmix_pkg::THR_OFFS_RST, top: rcmix_pkg::PWM_TOP_RST};
    apply_cfg(c);
  endtask

  // receiver holds off while words keep coming, so the input side backs up
  task automatic test_output_hold();
    hold_req_cnt <= hold_req_cnt + 1;
    test_random_capture(20);
  endtask

  initial begin
    mix_cfg = '{center: rcmix_pkg::CENTER_RST, steer_gain: rcmix_pkg::STEER_GAIN_RST,
                steer_offs: rcmix_pkg::STEER_OFFS_RST, thr_gain: rcmix_pkg::THR_GAIN_RST,
                thr_offs: rcmix_pkg::THR_OFFS_RST, top: rcmix_pkg::PWM_TOP_RST};
    for (int i = 0; i < NUM_CH; i++) begin
      cap_falling[i] = 1'b0;
      cap_rise[i] = '0;
      cap_per[i] = '0;
      cap_duty[i] = '0;
      nominal_per[i] = 16'd20000;
    end
    steer_val = '0;
    thr_val = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idle(14, 73);
    test_directed_edges();
    test_random_capture(110);
    set_idle(73, 14);
    test_config_settings();
    set_idle(0, 0);
    test_random_capture(100);
    test_output_hold();

    go_quiet();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rcmix_pkg.sv
hw/rtl/rcmix_sdiv.sv
hw/rtl/rcmix_smul.sv
hw/rtl/rc_pwm_capture_motor_mixer.sv
sim/rc_pwm_capture_motor_mixer_tb.sv
